@@ src/prq_pkg.sv @@
package prq_pkg;

   localparam int DEPTH    = 16;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int PID_W    = 16;
   localparam int PRIO_W   = 8;
   localparam int BIT_W    = $clog2(PRIO_W);
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - PID_W - PRIO_W - COUNT_W - 1;

   typedef enum logic [OP_W-1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_REM = 2'd2,
      OP_NOP = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC
   } state_type;

   // Broadcast control from the sequencer to every cell of the chain.
   typedef struct packed {
      op_type              op;
      logic                init_cand;
      logic                scan_step;
      logic                commit;
      logic                any_zero;
      logic [BIT_W-1:0]    bit_sel;
      logic [PID_W-1:0]    key_pid;
      logic [PRIO_W-1:0]   key_prio;
   } cell_ctrl_type;

endpackage

@@ src/prq_cell.sv @@
module prq_cell (
   input  logic                          clock,
   input  prq_pkg::cell_ctrl_type        ctrl,
   input  logic                          alive,
   input  logic                          tail,
   input  logic [prq_pkg::PID_W-1:0]     nxt_pid,
   input  logic [prq_pkg::PRIO_W-1:0]    nxt_prio,
   input  logic                          kill_in,
   input  logic [prq_pkg::PID_W-1:0]     sel_pid_in,
   input  logic [prq_pkg::PRIO_W-1:0]    sel_prio_in,
   output logic [prq_pkg::PID_W-1:0]     pid,
   output logic [prq_pkg::PRIO_W-1:0]    prio,
   output logic                          kill_out,
   output logic [prq_pkg::PID_W-1:0]     sel_pid_out,
   output logic [prq_pkg::PRIO_W-1:0]    sel_prio_out,
   output logic                          zero_vote
);

   logic [prq_pkg::PID_W-1:0]  pid_ff, pid_in;
   logic [prq_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic                       cand_ff, cand_in;
   logic                       hit;
   logic                       first;

   always_comb begin
      case (ctrl.op)
         prq_pkg::OP_DEQ: hit = cand_ff & alive;
         prq_pkg::OP_REM: hit = alive & (pid_ff == ctrl.key_pid);
         default:         hit = 1'b0;
      endcase
   end

   // Once a cell to the left has matched, every cell from the match onward
   // takes its right neighbor's entry, which closes the gap.
   assign kill_out = kill_in | hit;
   assign first    = hit & ~kill_in;

   assign sel_pid_out  = sel_pid_in  | (first ? pid_ff  : '0);
   assign sel_prio_out = sel_prio_in | (first ? prio_ff : '0);

   assign zero_vote = cand_ff & alive & ~prio_ff[ctrl.bit_sel];

   always_comb begin
      pid_in  = pid_ff;
      prio_in = prio_ff;
      if (ctrl.commit) begin
         if (kill_out) begin
            pid_in  = nxt_pid;
            prio_in = nxt_prio;
         end else if ((ctrl.op == prq_pkg::OP_ENQ) && tail) begin
            pid_in  = ctrl.key_pid;
            prio_in = ctrl.key_prio;
         end
      end
   end

   // A candidate with a one in the examined bit drops out when some other
   // candidate has a zero there.
   always_comb begin
      cand_in = cand_ff;
      if (ctrl.init_cand) begin
         cand_in = alive;
      end else if (ctrl.scan_step) begin
         cand_in = cand_ff & ~(ctrl.any_zero & prio_ff[ctrl.bit_sel]);
      end
   end

   always_ff @(posedge clock) begin
      pid_ff  <= pid_in;
      prio_ff <= prio_in;
      cand_ff <= cand_in;
   end

   assign pid  = pid_ff;
   assign prio = prio_ff;

endmodule

@@ src/priority_ready_queue_unit.sv @@
// Result registered in the EXEC state after acceptance; a dequeue from a non-empty queue
// first runs the bit-serial minimum scan in the SCAN state, from the top priority bit down to bit 0.
// One request at a time; the next is accepted in the cycle the result appears, and EXEC
// waits while an earlier result is still held on the output by a stall.
// Synchronous active-high reset empties the queue, clears the sequencer and the
// result valid; entry storage is not cleared and is only read below the count.
module priority_ready_queue_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [15:0] entry_pid, [23:16] entry_prio
   input  logic [prq_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [prq_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [15:0] out_pid, [23:16] out_prio, [28:24] count, [29] is_empty, [31:30] zero
   output logic [prq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [prq_pkg::STATUS_W-1:0]   rsp_tuser
);

   localparam int DEPTH = prq_pkg::DEPTH;
   localparam int CNT_W = prq_pkg::CNT_W;

   prq_pkg::state_type               state_ff, state_in;
   prq_pkg::op_type                  op_ff, op_in;
   logic [prq_pkg::PID_W-1:0]        key_pid_ff, key_pid_in;
   logic [prq_pkg::PRIO_W-1:0]       key_prio_ff, key_prio_in;
   logic [prq_pkg::BIT_W-1:0]        bit_ff, bit_in;
   logic [CNT_W-1:0]                 count_ff, count_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   prq_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [prq_pkg::PID_W-1:0]        rsp_pid_ff, rsp_pid_in;
   logic [prq_pkg::PRIO_W-1:0]       rsp_prio_ff, rsp_prio_in;
   logic [CNT_W-1:0]                 rsp_count_ff, rsp_count_in;

   prq_pkg::cell_ctrl_type           ctrl;
   logic                             req_accept;
   logic                             full;
   logic                             found;

   logic [prq_pkg::PID_W-1:0]        cell_pid [DEPTH];
   logic [prq_pkg::PRIO_W-1:0]       cell_prio [DEPTH];
   logic [DEPTH:0]                   kill;
   logic [prq_pkg::PID_W-1:0]        sel_pid [DEPTH+1];
   logic [prq_pkg::PRIO_W-1:0]       sel_prio [DEPTH+1];
   logic [DEPTH-1:0]                 zero_vote;

   assign kill[0]     = 1'b0;
   assign sel_pid[0]  = '0;
   assign sel_prio[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [prq_pkg::PID_W-1:0]  nxt_pid;
      logic [prq_pkg::PRIO_W-1:0] nxt_prio;
      if (i == DEPTH - 1) begin : g_last
         assign nxt_pid  = '0;
         assign nxt_prio = '0;
      end else begin : g_mid
         assign nxt_pid  = cell_pid[i+1];
         assign nxt_prio = cell_prio[i+1];
      end
      prq_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .alive        (count_ff > CNT_W'(i)),
         .tail         (count_ff == CNT_W'(i)),
         .nxt_pid      (nxt_pid),
         .nxt_prio     (nxt_prio),
         .kill_in      (kill[i]),
         .sel_pid_in   (sel_pid[i]),
         .sel_prio_in  (sel_prio[i]),
         .pid          (cell_pid[i]),
         .prio         (cell_prio[i]),
         .kill_out     (kill[i+1]),
         .sel_pid_out  (sel_pid[i+1]),
         .sel_prio_out (sel_prio[i+1]),
         .zero_vote    (zero_vote[i])
      );
   end

   assign req_tready = (state_ff == prq_pkg::ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign found      = kill[DEPTH];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_pid_in    = key_pid_ff;
      key_prio_in   = key_prio_ff;
      bit_in        = bit_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_count_in  = rsp_count_ff;

      ctrl.op        = op_ff;
      ctrl.init_cand = 1'b0;
      ctrl.scan_step = 1'b0;
      ctrl.commit    = 1'b0;
      ctrl.any_zero  = |zero_vote;
      ctrl.bit_sel   = bit_ff;
      ctrl.key_pid   = key_pid_ff;
      ctrl.key_prio  = key_prio_ff;

      case (state_ff)
         prq_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in       = prq_pkg::op_type'(req_tuser);
               key_pid_in  = req_tdata[prq_pkg::PID_W-1:0];
               key_prio_in = req_tdata[prq_pkg::PID_W +: prq_pkg::PRIO_W];
               bit_in      = prq_pkg::BIT_W'(prq_pkg::PRIO_W - 1);
               if ((prq_pkg::op_type'(req_tuser) == prq_pkg::OP_DEQ) &&
                   (count_ff != '0)) begin
                  ctrl.init_cand = 1'b1;
                  state_in       = prq_pkg::ST_SCAN;
               end else begin
                  state_in = prq_pkg::ST_EXEC;
               end
            end
         end
         prq_pkg::ST_SCAN: begin
            ctrl.scan_step = 1'b1;
            bit_in         = bit_ff - prq_pkg::BIT_W'(1);
            if (bit_ff == '0) begin
               state_in = prq_pkg::ST_EXEC;
            end
         end
         prq_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ctrl.commit   = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_pid_in    = sel_pid[DEPTH];
               rsp_prio_in   = sel_prio[DEPTH];
               rsp_status_in = prq_pkg::STAT_OK;
               case (op_ff)
                  prq_pkg::OP_ENQ: begin
                     if (full) begin
                        rsp_status_in = prq_pkg::STAT_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  prq_pkg::OP_DEQ: begin
                     if (count_ff == '0) begin
                        rsp_status_in = prq_pkg::STAT_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  prq_pkg::OP_REM: begin
                     if (found) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        rsp_status_in = prq_pkg::STAT_NOTFOUND;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
               state_in     = prq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_pid_ff    <= key_pid_in;
      key_prio_ff   <= key_prio_in;
      bit_ff        <= bit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{prq_pkg::RSP_PAD_W{1'b0}},
                        (rsp_count_ff == '0),
                        prq_pkg::COUNT_W'(rsp_count_ff),
                        rsp_prio_ff,
                        rsp_pid_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds its depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == prq_pkg::STAT_FULL))
         |-> (rsp_count_ff == CNT_W'(DEPTH)))
      else $error("full status reported while the queue had room");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (ctrl.commit && (op_ff == prq_pkg::OP_DEQ) && (count_ff != '0))
         |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("dequeue from a non-empty queue did not shrink it");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != prq_pkg::STAT_OK))
         |-> ((rsp_pid_ff == '0) && (rsp_prio_ff == '0)))
      else $error("failed request returned a nonzero entry");

   a_deq_found: assert property (@(posedge clock) disable iff (reset)
      (ctrl.commit && (op_ff == prq_pkg::OP_DEQ) && (count_ff != '0)) |-> found)
      else $error("minimum scan left no candidate in a non-empty queue");

endmodule
